// ----- design/sbsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sbsm_pkg;

    localparam int unsigned AddrW     = 16;
    localparam int unsigned DataW     = 8;
    localparam int unsigned RegW      = 5;
    localparam int unsigned RomAddrW  = 19;
    localparam int unsigned OffsW     = 14;
    localparam int unsigned CountW    = 6;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 6;

    localparam logic [RegW-1:0]   LoaderMark   = 5'h10;
    localparam logic [RegW-1:0]   ControlReset = 5'h0C;
    localparam logic [CountW-1:0] BankCountRst = 6'd32;

    localparam logic [AddrW-1:0] RomBase   = 16'h8000;
    localparam logic [AddrW-1:0] ChrLoBase = 16'hA000;
    localparam logic [AddrW-1:0] UpperBase = 16'hC000;
    localparam logic [AddrW-1:0] PrgBase   = 16'hE000;

    localparam logic [CfgIdxW-1:0] CfgBankCount  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgChrPresent = 2'd1;

    localparam logic [1:0] PrgMode32a  = 2'd0;
    localparam logic [1:0] PrgMode32b  = 2'd1;
    localparam logic [1:0] PrgModeFix0 = 2'd2;
    localparam logic [1:0] PrgModeFixL = 2'd3;

    localparam logic [1:0] MirOneScreen = 2'd0;
    localparam logic [1:0] MirVertical  = 2'd1;
    localparam logic [1:0] MirHoriz     = 2'd2;

    localparam logic [1:0] CtlMirVert  = 2'd2;
    localparam logic [1:0] CtlMirHoriz = 2'd3;

    typedef struct packed {
        logic             kind;
        logic [AddrW-1:0] address;
        logic [DataW-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic                rom_hit;
        logic [RomAddrW-1:0] rom_address;
        logic                passthrough;
        logic [1:0]          mirroring;
        logic [RegW-1:0]     chr_bank_low;
        logic [RegW-1:0]     chr_bank_high;
        logic                register_committed;
        logic                chr_reload;
    } t_out_item;

    typedef struct packed {
        logic [RegW-1:0] control;
        logic [RegW-1:0] chr_low;
        logic [RegW-1:0] chr_high;
        logic [RegW-1:0] prg_bank;
    } t_bank_state;

endpackage

`default_nettype wire

// ----- design/serial_bank_switch_mapper_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake               | payload
// in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
// out     | output    | o_out_valid/ i_out_stall| o_out_data (t_out_item)
// cfg     | input     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// One beat per cycle while the output is not stalled; each beat passes the input register, then the result register.
// Mapper state updates as the beat leaves the input register into the result register.
// Sync active-low reset: loader at marker, control 0x0C, banks 0, count 32, CHR ROM on.
// Output stall holds the result register and backs up into the input register.

module serial_bank_switch_mapper_top (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire sbsm_pkg::t_in_item         i_in_data,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output sbsm_pkg::t_out_item             o_out_data,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [sbsm_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire [sbsm_pkg::CfgDataW-1:0]    i_cfg_data
);

    logic                          r_s1_valid;
    sbsm_pkg::t_in_item            r_s1;
    logic                          r_out_valid;
    sbsm_pkg::t_out_item           r_out;
    sbsm_pkg::t_out_item           n_out;
    logic [sbsm_pkg::CountW-1:0]   r_bank_count;
    logic                          r_chr_present;
    logic                          s1_adv;
    sbsm_pkg::t_bank_state         cur_state;
    sbsm_pkg::t_bank_state         nxt_state;
    logic                          committed;
    logic [sbsm_pkg::RomAddrW-1:0] mapped;
    logic                          in_rom;

    assign s1_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_count  <= sbsm_pkg::BankCountRst;
            r_chr_present <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sbsm_pkg::CfgBankCount:  r_bank_count  <= i_cfg_data;
                sbsm_pkg::CfgChrPresent: r_chr_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1 <= i_in_data;
        end
    end

    sbsm_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_adv),
        .i_item      (r_s1),
        .o_state     (cur_state),
        .o_next      (nxt_state),
        .o_committed (committed)
    );

    sbsm_prg_map u_map (
        .i_state       (cur_state),
        .i_bank_count  (r_bank_count),
        .i_address     (r_s1.address),
        .o_rom_address (mapped)
    );

    assign in_rom = r_s1.address >= sbsm_pkg::RomBase;

    always_comb begin
        n_out.rom_hit            = in_rom && !r_s1.kind;
        n_out.rom_address        = n_out.rom_hit ? mapped : '0;
        n_out.passthrough        = !in_rom;
        case (nxt_state.control[1:0])
            sbsm_pkg::CtlMirVert:  n_out.mirroring = sbsm_pkg::MirVertical;
            sbsm_pkg::CtlMirHoriz: n_out.mirroring = sbsm_pkg::MirHoriz;
            default:               n_out.mirroring = sbsm_pkg::MirOneScreen;
        endcase
        n_out.chr_bank_low       = nxt_state.chr_low;
        n_out.chr_bank_high      = nxt_state.chr_high;
        n_out.register_committed = committed;
        n_out.chr_reload         = committed && r_chr_present;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_commit_is_rom_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.register_committed |-> !r_out.rom_hit && !r_out.passthrough)
        else $error("commit flagged on a read or pass-through beat");

    a_reload_needs_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.chr_reload |-> r_out.register_committed)
        else $error("reload without commit");

    a_stalled_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_s1_valid && $stable(r_s1))
        else $error("input register changed while stalled");

    a_miss_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.rom_hit |-> r_out.rom_address == '0)
        else $error("ROM address on a non-hit beat");

endmodule

`default_nettype wire

// ----- design/sbsm_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbsm_regs (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  wire sbsm_pkg::t_in_item i_item,
    output sbsm_pkg::t_bank_state o_state,
    output sbsm_pkg::t_bank_state o_next,
    output logic                 o_committed
);

    logic [sbsm_pkg::RegW-1:0] r_loader;
    logic [sbsm_pkg::RegW-1:0] n_loader;
    logic [sbsm_pkg::RegW-1:0] shifted;
    sbsm_pkg::t_bank_state     r_state;
    sbsm_pkg::t_bank_state     n_state;
    logic                      is_rom_write;

    assign is_rom_write = i_item.kind && (i_item.address >= sbsm_pkg::RomBase);
    assign shifted      = {i_item.write_data[0], r_loader[sbsm_pkg::RegW-1:1]};

    always_comb begin
        n_loader    = r_loader;
        n_state     = r_state;
        o_committed = 1'b0;
        if (is_rom_write) begin
            if (i_item.write_data[sbsm_pkg::DataW-1]) begin
                n_loader = sbsm_pkg::LoaderMark;
            end else if (r_loader[0]) begin
                n_loader    = sbsm_pkg::LoaderMark;
                o_committed = 1'b1;
                if (i_item.address < sbsm_pkg::ChrLoBase) begin
                    n_state.control = shifted;
                end else if (i_item.address < sbsm_pkg::UpperBase) begin
                    n_state.chr_low = shifted;
                end else if (i_item.address < sbsm_pkg::PrgBase) begin
                    n_state.chr_high = shifted;
                end else begin
                    n_state.prg_bank = shifted;
                end
            end else begin
                n_loader = shifted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loader         <= sbsm_pkg::LoaderMark;
            r_state.control  <= sbsm_pkg::ControlReset;
            r_state.chr_low  <= '0;
            r_state.chr_high <= '0;
            r_state.prg_bank <= '0;
        end else if (i_step) begin
            r_loader <= n_loader;
            r_state  <= n_state;
        end
    end

    assign o_state = r_state;
    assign o_next  = n_state;

    a_loader_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loader != '0)
        else $error("serial loader lost its marker");

    a_commit_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_committed |=> r_loader == sbsm_pkg::LoaderMark)
        else $error("loader not rearmed after commit");

    a_commit_needs_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_committed |-> r_loader[0] && is_rom_write)
        else $error("commit without fifth bit");

endmodule

`default_nettype wire

// ----- design/sbsm_prg_map.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbsm_prg_map (
    input  wire sbsm_pkg::t_bank_state      i_state,
    input  wire [sbsm_pkg::CountW-1:0]      i_bank_count,
    input  wire [sbsm_pkg::AddrW-1:0]       i_address,
    output logic [sbsm_pkg::RomAddrW-1:0]   o_rom_address
);

    logic [sbsm_pkg::RegW-1:0]   lower;
    logic [sbsm_pkg::RegW-1:0]   upper;
    logic [sbsm_pkg::RegW-1:0]   bank;
    logic [sbsm_pkg::CountW-1:0] last_bank;

    assign last_bank = i_bank_count - sbsm_pkg::CountW'(1);

    always_comb begin
        case (i_state.control[3:2])
            sbsm_pkg::PrgModeFix0: begin
                lower = '0;
                upper = i_state.prg_bank;
            end
            sbsm_pkg::PrgModeFixL: begin
                lower = i_state.prg_bank;
                upper = last_bank[sbsm_pkg::RegW-1:0];
            end
            default: begin
                lower = {i_state.prg_bank[sbsm_pkg::RegW-1:1], 1'b0};
                upper = {i_state.prg_bank[sbsm_pkg::RegW-1:1], 1'b1};
            end
        endcase
    end

    assign bank          = (i_address >= sbsm_pkg::UpperBase) ? upper : lower;
    assign o_rom_address = {bank, i_address[sbsm_pkg::OffsW-1:0]};

endmodule

`default_nettype wire

// ----- sim/serial_bank_switch_mapper_top_test.sv -----
`timescale 1ns / 1ps

module serial_bank_switch_mapper_top_test;

    localparam logic KindRead  = 1'b0;
    localparam logic KindWrite = 1'b1;

    localparam logic [sbsm_pkg::CfgIdxW-1:0] CfgSpare2 = 2'd2;
    localparam logic [sbsm_pkg::CfgIdxW-1:0] CfgSpare3 = 2'd3;

    localparam int DeadLimit = 2000;
    localparam int MaxShown  = 10;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    sbsm_pkg::t_in_item            in_data = '0;
    logic                          out_stall = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [sbsm_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [sbsm_pkg::CfgDataW-1:0] cfg_data = '0;

    wire                 o_in_stall;
    wire                 o_out_valid;
    sbsm_pkg::t_out_item o_out_data;
    wire                 o_cfg_ready;

    serial_bank_switch_mapper_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mapper shadow state
    logic [sbsm_pkg::RegW-1:0]   loader_sr;
    logic [sbsm_pkg::RegW-1:0]   ctl_reg;
    logic [sbsm_pkg::RegW-1:0]   chr_lo_reg;
    logic [sbsm_pkg::RegW-1:0]   chr_hi_reg;
    logic [sbsm_pkg::RegW-1:0]   prg_reg;
    logic [sbsm_pkg::CountW-1:0] bank_count;
    logic                        chr_present;

    sbsm_pkg::t_in_item  access_q[$];
    sbsm_pkg::t_out_item result_q[$];

    bit no_gaps = 1'b0;
    int send_wait = 0;
    int recv_wait = 0;
    int err_cnt = 0;
    int dead_cycles = 0;

    function automatic int draw_wait(input bit none);
        if (none) return 0;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 17);
            1: return $urandom_range(0, 2);
            default: return 0;
        endcase
    endfunction

    function automatic sbsm_pkg::t_out_item mapper_predict(input sbsm_pkg::t_in_item a);
        sbsm_pkg::t_out_item         r;
        logic [sbsm_pkg::RegW-1:0]   lo_bank;
        logic [sbsm_pkg::RegW-1:0]   hi_bank;
        logic [sbsm_pkg::RegW-1:0]   bank;
        logic [sbsm_pkg::RegW-1:0]   shifted;
        logic [sbsm_pkg::CountW-1:0] last_bank;
        r = '0;
        if (a.address < sbsm_pkg::RomBase) begin
            r.passthrough = 1'b1;
        end else if (a.kind == KindRead) begin
            case (ctl_reg[3:2])
                sbsm_pkg::PrgModeFix0: begin
                    lo_bank = '0;
                    hi_bank = prg_reg;
                end
                sbsm_pkg::PrgModeFixL: begin
                    last_bank = bank_count - 1'b1;
                    lo_bank = prg_reg;
                    hi_bank = last_bank[sbsm_pkg::RegW-1:0];
                end
                default: begin
                    lo_bank = {prg_reg[sbsm_pkg::RegW-1:1], 1'b0};
                    hi_bank = lo_bank + 1'b1;
                end
            endcase
            bank = (a.address >= sbsm_pkg::UpperBase) ? hi_bank : lo_bank;
            r.rom_hit = 1'b1;
            r.rom_address = {bank, a.address[sbsm_pkg::OffsW-1:0]};
        end else if (a.write_data[7]) begin
            loader_sr = sbsm_pkg::LoaderMark;
        end else begin
            shifted = {a.write_data[0], loader_sr[sbsm_pkg::RegW-1:1]};
            if (loader_sr[0]) begin
                if (a.address < sbsm_pkg::ChrLoBase) begin
                    ctl_reg = shifted;
                end else if (a.address < sbsm_pkg::UpperBase) begin
                    chr_lo_reg = shifted;
                end else if (a.address < sbsm_pkg::PrgBase) begin
                    chr_hi_reg = shifted;
                end else begin
                    prg_reg = shifted;
                end
                loader_sr = sbsm_pkg::LoaderMark;
                r.register_committed = 1'b1;
            end else begin
                loader_sr = shifted;
            end
        end
        case (ctl_reg[1:0])
            sbsm_pkg::CtlMirVert:  r.mirroring = sbsm_pkg::MirVertical;
            sbsm_pkg::CtlMirHoriz: r.mirroring = sbsm_pkg::MirHoriz;
            default:               r.mirroring = sbsm_pkg::MirOneScreen;
        endcase
        r.chr_bank_low = chr_lo_reg;
        r.chr_bank_high = chr_hi_reg;
        r.chr_reload = r.register_committed & chr_present;
        return r;
    endfunction

    task automatic check_result(input sbsm_pkg::t_out_item got);
        sbsm_pkg::t_out_item want;
        if (result_q.size() == 0) begin
            if (err_cnt < MaxShown) $display("result beat with nothing expected: %p", got);
            err_cnt++;
        end else begin
            want = result_q.pop_front();
            if (got !== want) begin
                if (err_cnt < MaxShown) begin
                    $display({"mismatch: exp hit=%0d addr=%05h pass=%0d mir=%0d",
                              " lo=%0d hi=%0d com=%0d rld=%0d"},
                             want.rom_hit, want.rom_address, want.passthrough,
                             want.mirroring, want.chr_bank_low, want.chr_bank_high,
                             want.register_committed, want.chr_reload);
                    $display({"          got hit=%0d addr=%05h pass=%0d mir=%0d",
                              " lo=%0d hi=%0d com=%0d rld=%0d"},
                             got.rom_hit, got.rom_address, got.passthrough,
                             got.mirroring, got.chr_bank_low, got.chr_bank_high,
                             got.register_committed, got.chr_reload);
                end
                err_cnt++;
            end
        end
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                result_q.push_back(mapper_predict(in_data));
            end
            if (!in_valid || !o_in_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end else if (access_q.size() != 0) begin
                    in_data <= access_q.pop_front();
                    in_valid <= 1'b1;
                    send_wait = draw_wait(no_gaps);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                check_result(o_out_data);
                recv_wait = draw_wait(no_gaps);
            end
            if (recv_wait > 0) begin
                out_stall <= 1'b1;
                recv_wait--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            dead_cycles <= 0;
        end else if (dead_cycles >= DeadLimit) begin
            $display("[serial_bank_switch_mapper_top] ERROR");
            $finish;
        end else begin
            dead_cycles <= dead_cycles + 1;
        end
    end

    task automatic add_item(input logic kind, input logic [sbsm_pkg::AddrW-1:0] addr,
                            input logic [sbsm_pkg::DataW-1:0] data);
        sbsm_pkg::t_in_item it;
        it.kind = kind;
        it.address = addr;
        it.write_data = data;
        access_q.push_back(it);
    endtask

    // five single-bit writes, LSB first; only the last address selects the register
    task automatic queue_serial(input logic [sbsm_pkg::AddrW-1:0] target,
                                input logic [sbsm_pkg::RegW-1:0] val);
        for (int i = 0; i < sbsm_pkg::RegW; i++) begin
            add_item(KindWrite, (i == sbsm_pkg::RegW - 1) ? target : {1'b1, 15'($urandom)},
                     {1'b0, 6'($urandom), val[i]});
        end
    endtask

    task automatic queue_random(input int n);
        int                         added;
        int                         pick;
        int                         k;
        logic [sbsm_pkg::AddrW-1:0] a;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                queue_serial({1'b1, 2'($urandom), 13'($urandom)}, 5'($urandom));
                added += sbsm_pkg::RegW;
            end else if (pick < 75) begin
                a = {1'b1, 15'($urandom)};
                case ($urandom_range(0, 7))
                    0: a = 16'hFFFF;
                    1: a = sbsm_pkg::UpperBase;
                    2: a = sbsm_pkg::UpperBase - 1'b1;
                    3: a = sbsm_pkg::RomBase;
                    default: ;
                endcase
                add_item(KindRead, a, 8'($urandom));
                added++;
            end else if (pick < 85) begin
                add_item(KindWrite, {1'b1, 15'($urandom)}, 8'($urandom) | 8'h80);
                added++;
            end else if (pick < 95) begin
                add_item(1'($urandom), {1'b0, 15'($urandom)}, 8'($urandom));
                added++;
            end else begin
                // broken load, then loader clear
                k = $urandom_range(1, sbsm_pkg::RegW - 1);
                repeat (k) add_item(KindWrite, {1'b1, 15'($urandom)}, {1'b0, 7'($urandom)});
                add_item(KindWrite, {1'b1, 15'($urandom)}, 8'($urandom) | 8'h80);
                added += k + 1;
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (access_q.size() != 0 || in_valid || result_q.size() != 0);
    endtask

    task automatic write_cfg(input logic [sbsm_pkg::CfgIdxW-1:0] idx,
                             input logic [sbsm_pkg::CfgDataW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sbsm_pkg::CfgBankCount) begin
            bank_count = val;
        end else if (idx == sbsm_pkg::CfgChrPresent) begin
            chr_present = val[0];
        end
    endtask

    task automatic run_phase(input logic [sbsm_pkg::CountW-1:0] count, input logic chr,
                             input bit none, input int n);
        logic [sbsm_pkg::CfgDataW-1:0] v;
        wait_idle();
        write_cfg(sbsm_pkg::CfgBankCount, count);
        v = sbsm_pkg::CfgDataW'($urandom);
        v[0] = chr;
        write_cfg(sbsm_pkg::CfgChrPresent, v);
        write_cfg($urandom_range(0, 1) ? CfgSpare2 : CfgSpare3, sbsm_pkg::CfgDataW'($urandom));
        @(negedge clk);
        no_gaps = none;
        queue_random(n);
    endtask

    initial begin
        loader_sr = sbsm_pkg::LoaderMark;
        ctl_reg = sbsm_pkg::ControlReset;
        chr_lo_reg = '0;
        chr_hi_reg = '0;
        prg_reg = '0;
        bank_count = sbsm_pkg::BankCountRst;
        chr_present = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset mapping: fixed last bank at the top window
        add_item(KindRead, sbsm_pkg::RomBase, 8'h00);
        add_item(KindRead, sbsm_pkg::UpperBase - 1'b1, 8'hFF);
        add_item(KindRead, sbsm_pkg::UpperBase, 8'h00);
        add_item(KindRead, 16'hFFFF, 8'hFF);
        add_item(KindRead, 16'h0000, 8'h00);
        add_item(KindWrite, 16'h7FFF, 8'hFF);
        // partial load dropped by a clear
        add_item(KindWrite, sbsm_pkg::RomBase, 8'h01);
        add_item(KindWrite, sbsm_pkg::RomBase, 8'h80);
        queue_serial(16'hFFFF, 5'h1F);
        add_item(KindRead, sbsm_pkg::RomBase, 8'h00);
        add_item(KindRead, 16'hFFFF, 8'h00);
        queue_serial(sbsm_pkg::RomBase, 5'h0B);
        add_item(KindRead, sbsm_pkg::RomBase, 8'h00);
        add_item(KindRead, sbsm_pkg::UpperBase, 8'h00);
        queue_serial(sbsm_pkg::PrgBase - 1'b1, 5'h1F);

        run_phase(6'd1, 1'b0, 1'b1, 300);
        run_phase(6'd63, 1'b1, 1'b0, 300);
        run_phase(6'd0, 1'b0, 1'b0, 300);
        run_phase(6'd32, 1'b1, 1'b1, 250);
        run_phase(6'($urandom), 1'($urandom), 1'b0, 350);
        run_phase(6'($urandom_range(1, 32)), 1'($urandom), 1'b0, 350);

        wait_idle();
        repeat (4) @(posedge clk);
        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("[serial_bank_switch_mapper_top] OK");
        end else begin
            $display("[serial_bank_switch_mapper_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sbsm_pkg.sv
design/sbsm_regs.sv
design/sbsm_prg_map.sv
design/serial_bank_switch_mapper_top.sv
sim/serial_bank_switch_mapper_top_test.sv
